FILE: hw/rtl/battery_soc_kalman_estimator_core_assert.svh
// Assertion macros for the state-of-charge estimator checker.
`ifndef BATTERY_SOC_KALMAN_ESTIMATOR_CORE_ASSERT_SVH
`define BATTERY_SOC_KALMAN_ESTIMATOR_CORE_ASSERT_SVH

// Check c in the same cycle as a, outside reset.
`define BSOC_ASSERT_NOW(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("bsoc assertion failed");

// Check c in the cycle after a, outside reset.
`define BSOC_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("bsoc assertion failed");

// Check c in the cycle after a, reset included.
`define BSOC_ASSERT_NEXT_ALWAYS(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("bsoc assertion failed");

`endif

FILE: hw/rtl/bsoc_pkg.sv
// ----------------------------------------------------------------------------
// bsoc_pkg
// Shared types, codes and saturation helpers of the state-of-charge estimator.
// ----------------------------------------------------------------------------
package bsoc_pkg;

  localparam logic [1:0] MODE_PREDICT = 2'd0;
  localparam logic [1:0] MODE_UPDATE  = 2'd1;
  localparam logic [1:0] MODE_RESET   = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  localparam logic [2:0] REG_CAPACITY   = 3'd0;
  localparam logic [2:0] REG_EFFICIENCY = 3'd1;
  localparam logic [2:0] REG_CHG_NOISE  = 3'd2;
  localparam logic [2:0] REG_BIAS_NOISE = 3'd3;
  localparam logic [2:0] REG_OCV_SLOPE  = 3'd4;
  localparam logic [2:0] REG_VOLT_NOISE = 3'd5;

  localparam logic signed [47:0] SMAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic [47:0]        SMAG = 48'h8000_0000_0000;
  localparam logic signed [63:0] S64_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'shFFFF_8000_0000_0000;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [48:0] b;
    logic [6:0]         sh;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [47:0] q;
    logic [63:0]        raw;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [63:0]       n;
    logic [47:0]       d;
    logic signed [7:0] sh;
    logic              neg;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [47:0] q;
  } div_rsp_t;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > S64_MAX) return SMAX;
    if (v < S64_MIN) return $signed(SMAG);
    return v[47:0];
  endfunction

  function automatic logic signed [47:0] signed_sat(input logic [47:0] m, input logic neg);
    if (neg) return $signed(48'(-m));
    if (m > SMAX) return SMAX;
    return $signed(m);
  endfunction

  function automatic logic signed [63:0] ext48(input logic signed [47:0] v);
    return {{16{v[47]}}, v};
  endfunction

endpackage

FILE: hw/rtl/bsoc_if.sv
// ----------------------------------------------------------------------------
// bsoc_if
// Sample and result channels of the state-of-charge estimator.
// ----------------------------------------------------------------------------
interface bsoc_sample_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] current;
  logic [31:0]        time_step;
  logic signed [31:0] terminal_voltage;
  logic signed [31:0] ocv_at_soc;
  logic signed [31:0] initial_soc;

  modport source (output valid, mode, current, time_step, terminal_voltage, ocv_at_soc,
                  initial_soc, input ready);
  modport sink (input valid, mode, current, time_step, terminal_voltage, ocv_at_soc,
                initial_soc, output ready);
endinterface

interface bsoc_result_if;
  logic               valid;
  logic               ready;
  logic [16:0]        soc_estimate;
  logic signed [31:0] bias_estimate;
  logic               status;

  modport source (output valid, soc_estimate, bias_estimate, status, input ready);
  modport sink (input valid, soc_estimate, bias_estimate, status, output ready);
endinterface

FILE: hw/rtl/battery_soc_kalman_estimator_core.sv
// ----------------------------------------------------------------------------
// battery_soc_kalman_estimator_core
// Two-state Kalman estimator of battery charge and current-sensor bias.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: one beat per item; mode selects predict, voltage update
//   or reset. The block takes a beat only while its sequencer is idle.
//   result channel: one beat per item with charge, bias and status.
//   APB port: six registers at byte addresses 8*i, 64-bit data, to be written
//   only while no item is in flight; the user is bound, the block does not check.
// Sequencing (sample beat to result valid), W = 64 + STATE_FRAC_BITS:
//   reset, unused mode and skipped predict go straight to the result stage.
//   predict and update run their steps in turn; a skipped update stops at U_S.
//   Multiplies run on the shared 64x16 digit multiplier and divisions on the
//   bit-serial divider over a W-bit dividend; these set the rate.
// Reset: synchronous; registers take their defaults, charge and bias clear,
//   covariance loads 0.01 on the diagonal.
// Stall: a finished result waits in the output register; the block still
//   takes the next sample, and holds its own next result until the beat
//   goes out.
// ----------------------------------------------------------------------------
module battery_soc_kalman_estimator_core #(
  parameter int STATE_FRAC_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  bsoc_sample_if.sink          sample,
  bsoc_result_if.source        result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  localparam int F      = STATE_FRAC_BITS;
  localparam int IN_SH  = F - 16;
  localparam int NUM_W  = 64 + F;
  localparam int RV_L   = (F >= 32) ? F - 32 : 0;
  localparam int RV_R   = (F >= 32) ? 0 : 32 - F;
  localparam logic signed [63:0] ONE_F  = 64'sd1 <<< F;
  localparam logic signed [63:0] HALF_F = ONE_F >>> 1;
  localparam logic signed [47:0] COV_INIT = 48'(ONE_F / 100);
  localparam logic signed [47:0] TINY = 48'(ONE_F / 1000000000);
  localparam logic [6:0] SH_F  = 7'(F);
  localparam logic [6:0] SH_N  = 7'(56 - F);
  localparam logic [6:0] SH_16 = 7'd16;
  localparam logic [6:0] SH_0  = 7'd0;
  localparam logic signed [7:0] GAIN_SH = 8'(F - 30);
  localparam logic signed [7:0] DIV_SH  = 8'(F);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_EMIT} state_t;
  typedef enum logic [4:0] {
    P_EFFDT, P_GAIN, P_DCHG, P_G01, P_GG, P_GG11, P_CN, P_G11, P_BN,
    U_Y, U_PS, U_S, U_K0, U_PT, U_K1, U_CHG, U_BIAS, U_KS0, U_KS1,
    U_C00, U_C01, U_C10, U_C11
  } step_t;

  // configuration
  logic [31:0]        capacity_ah;
  logic [30:0]        charge_efficiency;
  logic [39:0]        charge_noise;
  logic [39:0]        bias_noise;
  logic signed [31:0] ocv_slope;
  logic [39:0]        voltage_noise;

  // filter state
  logic signed [47:0] charge, bias, cov00, cov01, cov10, cov11;

  // sequencer
  state_t             state;
  step_t              step;
  logic               status;
  logic signed [31:0] cur;
  logic [31:0]        dt;
  logic signed [31:0] vt;
  logic signed [31:0] ocv;
  logic [63:0]        num;
  logic signed [47:0] g, y, ps, s, k0, k1, ks0, ks1, ta, tb, tc, td;

  bsoc_pkg::mul_req_t mreq;
  bsoc_pkg::mul_rsp_t mrsp;
  bsoc_pkg::div_req_t dreq;
  bsoc_pkg::div_rsp_t drsp;

  logic               use_div;
  logic signed [47:0] uq;
  logic               udone;
  logic signed [63:0] cur_s, vt_s, ocv_s;
  logic signed [48:0] sl;
  logic [48:0]        rv_w;
  logic signed [63:0] rv;
  logic [47:0]        cap3600;
  logic signed [47:0] chg_new, bias_new, y_new, s_new;
  logic [16:0]        init_c;
  logic [47:0]        bmag;
  logic [47:0]        bm;
  logic [31:0]        bias_out;
  logic               wr;

  function automatic logic signed [47:0] clamp_unit(input logic signed [63:0] v);
    if (v < 0) return '0;
    if (v > ONE_F) return 48'(ONE_F);
    return v[47:0];
  endfunction

  bsoc_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  bsoc_div #(.NUM_W(NUM_W)) u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // APB
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_ah       <= 32'd131072;
      charge_efficiency <= 31'd1073741824;
      charge_noise      <= 40'd109951;
      bias_noise        <= 40'd1099512;
      ocv_slope         <= 32'sd32768;
      voltage_noise     <= 40'd4294967;
    end else if (wr) begin
      case (paddr[5:3])
        bsoc_pkg::REG_CAPACITY:   capacity_ah       <= pwdata[31:0];
        bsoc_pkg::REG_EFFICIENCY: charge_efficiency <= pwdata[30:0];
        bsoc_pkg::REG_CHG_NOISE:  charge_noise      <= pwdata[39:0];
        bsoc_pkg::REG_BIAS_NOISE: bias_noise        <= pwdata[39:0];
        bsoc_pkg::REG_OCV_SLOPE:  ocv_slope         <= pwdata[31:0];
        bsoc_pkg::REG_VOLT_NOISE: voltage_noise     <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      bsoc_pkg::REG_CAPACITY:   prdata = {32'd0, capacity_ah};
      bsoc_pkg::REG_EFFICIENCY: prdata = {33'd0, charge_efficiency};
      bsoc_pkg::REG_CHG_NOISE:  prdata = {24'd0, charge_noise};
      bsoc_pkg::REG_BIAS_NOISE: prdata = {24'd0, bias_noise};
      bsoc_pkg::REG_OCV_SLOPE:  prdata = {{32{ocv_slope[31]}}, ocv_slope};
      bsoc_pkg::REG_VOLT_NOISE: prdata = {24'd0, voltage_noise};
      default:                  prdata = '0;
    endcase
  end

  // operand datapath
  assign cur_s   = $signed({{32{cur[31]}}, cur}) <<< IN_SH;
  assign vt_s    = $signed({{32{vt[31]}}, vt}) <<< IN_SH;
  assign ocv_s   = $signed({{32{ocv[31]}}, ocv}) <<< IN_SH;
  assign sl      = (ocv_slope > 0) ? {{17{ocv_slope[31]}}, ocv_slope} : 49'sd32768;
  assign rv_w    = ({9'd0, voltage_noise} << RV_L) >> RV_R;
  assign rv      = (rv_w > 49'(bsoc_pkg::SMAX)) ? bsoc_pkg::ext48(bsoc_pkg::SMAX)
                                                 : $signed({15'd0, rv_w});
  assign cap3600 = {16'd0, capacity_ah} * 48'd3600;

  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = '0;
    mreq.b     = '0;
    mreq.sh    = SH_F;
    dreq.start = 1'b0;
    dreq.n     = '0;
    dreq.d     = s;
    dreq.sh    = DIV_SH;
    dreq.neg   = 1'b0;
    use_div    = 1'b0;
    case (step)
      P_EFFDT: begin
        mreq.a  = {33'd0, charge_efficiency};
        mreq.b  = {17'd0, dt};
        mreq.sh = SH_0;
      end
      P_GAIN: begin
        use_div = 1'b1;
        dreq.n  = num;
        dreq.d  = cap3600;
        dreq.sh = GAIN_SH;
      end
      P_DCHG: begin
        mreq.a = cur_s - bsoc_pkg::ext48(bias);
        mreq.b = 49'(g);
      end
      P_G01: begin
        mreq.a = bsoc_pkg::ext48(cov01) + bsoc_pkg::ext48(cov10);
        mreq.b = 49'(g);
      end
      P_GG: begin
        mreq.a = bsoc_pkg::ext48(g);
        mreq.b = 49'(g);
      end
      P_GG11: begin
        mreq.a = bsoc_pkg::ext48(tb);
        mreq.b = 49'(cov11);
      end
      P_CN: begin
        mreq.a  = {24'd0, charge_noise};
        mreq.b  = {17'd0, dt};
        mreq.sh = SH_N;
      end
      P_G11: begin
        mreq.a = bsoc_pkg::ext48(g);
        mreq.b = 49'(cov11);
      end
      P_BN: begin
        mreq.a  = {24'd0, bias_noise};
        mreq.b  = {17'd0, dt};
        mreq.sh = SH_N;
      end
      U_Y: begin
        mreq.a  = bsoc_pkg::ext48(charge) - HALF_F;
        mreq.b  = sl;
        mreq.sh = SH_16;
      end
      U_PS: begin
        mreq.a  = bsoc_pkg::ext48(cov00);
        mreq.b  = sl;
        mreq.sh = SH_16;
      end
      U_S: begin
        mreq.a  = bsoc_pkg::ext48(ps);
        mreq.b  = sl;
        mreq.sh = SH_16;
      end
      U_K0: begin
        use_div  = 1'b1;
        dreq.n   = {16'd0, ps[47] ? 48'(-ps) : 48'(ps)};
        dreq.neg = ps[47];
      end
      U_PT: begin
        mreq.a  = bsoc_pkg::ext48(cov10);
        mreq.b  = sl;
        mreq.sh = SH_16;
      end
      U_K1: begin
        use_div  = 1'b1;
        dreq.n   = {16'd0, ta[47] ? 48'(-ta) : 48'(ta)};
        dreq.neg = ta[47];
      end
      U_CHG: begin
        mreq.a = bsoc_pkg::ext48(y);
        mreq.b = 49'(k0);
      end
      U_BIAS: begin
        mreq.a = bsoc_pkg::ext48(y);
        mreq.b = 49'(k1);
      end
      U_KS0: begin
        mreq.a  = bsoc_pkg::ext48(k0);
        mreq.b  = sl;
        mreq.sh = SH_16;
      end
      U_KS1: begin
        mreq.a  = bsoc_pkg::ext48(k1);
        mreq.b  = sl;
        mreq.sh = SH_16;
      end
      U_C00: begin
        mreq.a = bsoc_pkg::ext48(ks0);
        mreq.b = 49'(cov00);
      end
      U_C01: begin
        mreq.a = bsoc_pkg::ext48(ks0);
        mreq.b = 49'(cov01);
      end
      U_C10: begin
        mreq.a = bsoc_pkg::ext48(ks1);
        mreq.b = 49'(cov00);
      end
      U_C11: begin
        mreq.a = bsoc_pkg::ext48(ks1);
        mreq.b = 49'(cov01);
      end
      default: ;
    endcase
    mreq.start = (state == S_RUN) && !use_div;
    dreq.start = (state == S_RUN) && use_div;
  end

  assign uq       = use_div ? drsp.q : mrsp.q;
  assign udone    = use_div ? drsp.done : mrsp.done;
  assign chg_new  = clamp_unit(bsoc_pkg::ext48(charge) + bsoc_pkg::ext48(uq));
  assign bias_new = bsoc_pkg::sat48(bsoc_pkg::ext48(bias) + bsoc_pkg::ext48(uq));
  assign y_new    = bsoc_pkg::sat48(vt_s - ocv_s - bsoc_pkg::ext48(uq));
  assign s_new    = bsoc_pkg::sat48(bsoc_pkg::ext48(uq) + rv);

  assign init_c = (sample.initial_soc < 0) ? 17'd0 :
                  (sample.initial_soc > 32'sd65536) ? 17'd65536 : sample.initial_soc[16:0];

  assign bmag     = bias[47] ? 48'(-bias) : 48'(bias);
  assign bm       = bmag >> IN_SH;
  assign bias_out = bias[47] ? ((bm > 48'h8000_0000) ? 32'h8000_0000 : 32'(-bm))
                             : ((bm > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : bm[31:0]);

  assign sample.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= P_EFFDT;
      status       <= 1'b0;
      result.valid <= 1'b0;
      charge       <= '0;
      bias         <= '0;
      cov00        <= COV_INIT;
      cov01        <= '0;
      cov10        <= '0;
      cov11        <= COV_INIT;
    end else begin
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            cur <= sample.current;
            dt  <= sample.time_step;
            vt  <= sample.terminal_voltage;
            ocv <= sample.ocv_at_soc;
            case (sample.mode)
              bsoc_pkg::MODE_PREDICT: begin
                if (sample.time_step == '0 || capacity_ah == '0) begin
                  status <= 1'b1;
                  state  <= S_EMIT;
                end else begin
                  step  <= P_EFFDT;
                  state <= S_RUN;
                end
              end
              bsoc_pkg::MODE_UPDATE: begin
                step  <= U_Y;
                state <= S_RUN;
              end
              bsoc_pkg::MODE_RESET: begin
                charge <= 48'(init_c) << IN_SH;
                bias   <= '0;
                cov00  <= COV_INIT;
                cov01  <= '0;
                cov10  <= '0;
                cov11  <= COV_INIT;
                status <= 1'b0;
                state  <= S_EMIT;
              end
              default: begin
                status <= 1'b1;
                state  <= S_EMIT;
              end
            endcase
          end
        end
        S_RUN: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (udone) begin
            state <= S_RUN;
            step  <= step_t'(step + 5'd1);
            case (step)
              P_EFFDT: num <= mrsp.raw;
              P_GAIN:  g <= uq;
              P_DCHG:  charge <= chg_new;
              P_G01:   ta <= uq;
              P_GG:    tb <= uq;
              P_GG11:  tb <= uq;
              P_CN:    tc <= uq;
              P_G11:   td <= uq;
              P_BN: begin
                cov00  <= bsoc_pkg::sat48(bsoc_pkg::ext48(cov00) - bsoc_pkg::ext48(ta)
                                          + bsoc_pkg::ext48(tb) + bsoc_pkg::ext48(tc));
                cov01  <= bsoc_pkg::sat48(bsoc_pkg::ext48(cov01) - bsoc_pkg::ext48(td));
                cov10  <= bsoc_pkg::sat48(bsoc_pkg::ext48(cov10) - bsoc_pkg::ext48(td));
                cov11  <= bsoc_pkg::sat48(bsoc_pkg::ext48(cov11) + bsoc_pkg::ext48(uq));
                status <= 1'b0;
                state  <= S_EMIT;
              end
              U_Y:     y <= y_new;
              U_PS:    ps <= uq;
              U_S: begin
                s <= s_new;
                if (s_new <= TINY) begin
                  status <= 1'b1;
                  state  <= S_EMIT;
                end
              end
              U_K0:    k0 <= uq;
              U_PT:    ta <= uq;
              U_K1:    k1 <= uq;
              U_CHG:   charge <= chg_new;
              U_BIAS:  bias <= bias_new;
              U_KS0:   ks0 <= uq;
              U_KS1:   ks1 <= uq;
              U_C00:   ta <= uq;
              U_C01:   tb <= uq;
              U_C10:   tc <= uq;
              U_C11: begin
                cov00  <= bsoc_pkg::sat48(bsoc_pkg::ext48(cov00) - bsoc_pkg::ext48(ta));
                cov01  <= bsoc_pkg::sat48(bsoc_pkg::ext48(cov01) - bsoc_pkg::ext48(tb));
                cov10  <= bsoc_pkg::sat48(bsoc_pkg::ext48(cov10) - bsoc_pkg::ext48(tc));
                cov11  <= bsoc_pkg::sat48(bsoc_pkg::ext48(cov11) - bsoc_pkg::ext48(uq));
                status <= 1'b0;
                state  <= S_EMIT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_EMIT: begin
          if (!result.valid || result.ready) begin
            result.valid         <= 1'b1;
            result.soc_estimate  <= charge[IN_SH +: 17];
            result.bias_estimate <= $signed(bias_out);
            result.status        <= status;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/bsoc_mul.sv
// ----------------------------------------------------------------------------
// bsoc_mul
// Iterative signed multiplier, 16-bit digit a cycle, with shift and saturation.
// ----------------------------------------------------------------------------
module bsoc_mul (
  input  logic               clk,
  input  logic               rst,
  input  bsoc_pkg::mul_req_t req,
  output bsoc_pkg::mul_rsp_t rsp
);

  logic [63:0]  ma;
  logic [47:0]  mb;
  logic         neg;
  logic [6:0]   sh;
  logic [111:0] acc;
  logic [1:0]   cnt;
  logic         busy;
  logic         post;
  logic [63:0]  a_mag;
  logic [48:0]  b_mag;
  logic [79:0]  pp;
  logic [111:0] shifted;
  logic         over;
  logic [47:0]  m;

  assign a_mag = req.a[63] ? 64'(-req.a) : 64'(req.a);
  assign b_mag = req.b[48] ? 49'(-req.b) : 49'(req.b);
  assign pp    = {16'd0, ma} * {64'd0, mb[47:32]};
  assign shifted = acc >> sh;
  assign over    = (|shifted[111:48]) || (shifted[47:0] > bsoc_pkg::SMAG);
  assign m       = over ? bsoc_pkg::SMAG : shifted[47:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      post     <= 1'b0;
      cnt      <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        ma   <= a_mag;
        mb   <= b_mag[47:0];
        neg  <= req.a[63] ^ req.b[48];
        sh   <= req.sh;
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= (acc << 16) + {32'd0, pp};
        mb  <= mb << 16;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd2) begin
          busy <= 1'b0;
          post <= 1'b1;
        end
      end else if (post) begin
        post     <= 1'b0;
        rsp.done <= 1'b1;
        rsp.q    <= bsoc_pkg::signed_sat(m, neg);
        rsp.raw  <= acc[63:0];
      end
    end
  end

endmodule

FILE: hw/rtl/bsoc_div.sv
// ----------------------------------------------------------------------------
// bsoc_div
// Restoring divider, one quotient bit a cycle, saturated to the state range.
// ----------------------------------------------------------------------------
module bsoc_div #(
  parameter int NUM_W = 96
) (
  input  logic               clk,
  input  logic               rst,
  input  bsoc_pkg::div_req_t req,
  output bsoc_pkg::div_rsp_t rsp
);

  localparam int CW = $clog2(NUM_W);

  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] num_ext;
  logic [47:0]      d;
  logic [47:0]      rem;
  logic [47:0]      q;
  logic             ovf;
  logic             neg;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [48:0]      rem_sh;
  logic             ge;
  logic [48:0]      q_sh;
  logic [7:0]       rsh;

  assign num_ext = {{(NUM_W-64){1'b0}}, req.n};
  assign rsh     = 8'(-req.sh);
  assign rem_sh  = {rem, num[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, d};
  assign q_sh    = {q, ge};
  assign rsp     = {done, bsoc_pkg::signed_sat(ovf ? bsoc_pkg::SMAG : q, neg)};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        num  <= req.sh[7] ? (num_ext >> rsh) : (num_ext << req.sh);
        d    <= req.d;
        neg  <= req.neg;
        rem  <= '0;
        q    <= '0;
        ovf  <= 1'b0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? 48'(rem_sh - {1'b0, d}) : rem_sh[47:0];
        num <= num << 1;
        if (ovf || q_sh > {1'b0, bsoc_pkg::SMAG}) begin
          ovf <= 1'b1;
        end else begin
          q <= q_sh[47:0];
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/bsoc_checker.sv
// ----------------------------------------------------------------------------
// bsoc_checker
// Port-level checks of the state-of-charge estimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "battery_soc_kalman_estimator_core_assert.svh"

module bsoc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] soc_estimate
);

  `BSOC_ASSERT_NEXT(a_busy_after_beat, clk, rst, in_valid && in_ready, !in_ready)
  `BSOC_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_ready, out_valid)
  `BSOC_ASSERT_NOW(a_soc_in_range, clk, rst, out_valid, soc_estimate <= 17'd65536)
  `BSOC_ASSERT_NEXT_ALWAYS(a_reset_clears, clk, rst, !out_valid)

endmodule

bind battery_soc_kalman_estimator_core bsoc_checker u_bsoc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample.valid),
  .in_ready     (sample.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .soc_estimate (result.soc_estimate)
);

FILE: dv/battery_soc_kalman_estimator_core_test.sv
// ----------------------------------------------------------------------------
// battery_soc_kalman_estimator_core_test
// Drives reset, predict, voltage update and unused-mode samples into the
// charge estimator under several register settings and idle patterns, and
// compares every result beat with a fixed-point model of the two-state filter.
// ----------------------------------------------------------------------------
module battery_soc_kalman_estimator_core_test;

  localparam longint ST_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ST_MIN = -ST_MAX - 1;
  localparam logic [63:0] ST_MAG = 64'h0000_8000_0000_0000;
  localparam longint Q_ONE = 64'sh1_0000_0000;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] current;
    logic [31:0] time_step;
    logic [31:0] terminal_voltage;
    logic [31:0] ocv_at_soc;
    logic [31:0] initial_soc;
  } sample_t;

  typedef struct {
    logic [16:0] soc;
    logic [31:0] bias;
    logic        status;
  } estimate_t;

  class soc_scoreboard;
    logic [63:0] capacity, efficiency, chg_noise, bias_noise, volt_noise;
    longint slope;
    longint charge, bias, p00, p01, p10, p11;
    estimate_t pending[$];

    function new();
      capacity = 131072; efficiency = 1073741824; chg_noise = 109951;
      bias_noise = 1099512; slope = 32768; volt_noise = 4294967;
      charge = 0; bias = 0;
      load_cov();
    endfunction

    function void load_cov();
      p00 = Q_ONE / 100; p01 = 0; p10 = 0; p11 = Q_ONE / 100;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        bsoc_pkg::REG_CAPACITY:   capacity = {32'd0, v[31:0]};
        bsoc_pkg::REG_EFFICIENCY: efficiency = {33'd0, v[30:0]};
        bsoc_pkg::REG_CHG_NOISE:  chg_noise = {24'd0, v[39:0]};
        bsoc_pkg::REG_BIAS_NOISE: bias_noise = {24'd0, v[39:0]};
        bsoc_pkg::REG_OCV_SLOPE:  slope = longint'($signed(v[31:0]));
        bsoc_pkg::REG_VOLT_NOISE: volt_noise = {24'd0, v[39:0]};
        default: ;
      endcase
    endfunction

    function logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function longint clip48(longint v);
      return v > ST_MAX ? ST_MAX : (v < ST_MIN ? ST_MIN : v);
    endfunction

    function longint apply_sign(logic [63:0] m, bit neg);
      if (m > ST_MAG) m = ST_MAG;
      if (neg) return -longint'(m);
      return m > 64'(ST_MAX) ? ST_MAX : longint'(m);
    endfunction

    function longint fx_mul(longint a, longint b, int sh);
      logic [127:0] p;
      p = ({64'd0, magnitude(a)} * {64'd0, magnitude(b)}) >> sh;
      return apply_sign(p[127:64] != 0 ? ST_MAG + 1 : p[63:0], (a < 0) != (b < 0));
    endfunction

    function logic [63:0] fx_div(logic [63:0] n, logic [63:0] d, int sh);
      logic [127:0] q;
      if (d == 0) return ST_MAG + 1;
      q = ({64'd0, n} << sh) / {64'd0, d};
      return q > {64'd0, ST_MAG} ? ST_MAG + 1 : q[63:0];
    endfunction

    function bit predict(longint cur, logic [63:0] dt);
      longint g, dq, a00, a01, a10, a11;
      if (dt == 0 || capacity == 0) return 1;
      a00 = p00; a01 = p01; a10 = p10; a11 = p11;
      g = apply_sign(fx_div(efficiency * dt, capacity * 3600, 2), 0);
      dq = fx_mul(cur * 65536 - bias, g, 32);
      charge = charge + dq;
      charge = charge < 0 ? 0 : (charge > Q_ONE ? Q_ONE : charge);
      p00 = clip48(a00 - fx_mul(g, a01 + a10, 32) + fx_mul(fx_mul(g, g, 32), a11, 32)
                   + fx_mul(longint'(chg_noise), longint'(dt), 24));
      p01 = clip48(a01 - fx_mul(g, a11, 32));
      p10 = clip48(a10 - fx_mul(g, a11, 32));
      p11 = clip48(a11 + fx_mul(longint'(bias_noise), longint'(dt), 24));
      return 0;
    endfunction

    function bit correct(longint vt, longint ocv);
      longint sl, a00, a01, a10, a11, y, ps, s, k0, k1, ks0, ks1;
      sl = slope > 0 ? slope : 32768;
      a00 = p00; a01 = p01; a10 = p10; a11 = p11;
      y = clip48(vt * 65536 - ocv * 65536 - fx_mul(sl, charge - Q_ONE / 2, 16));
      ps = fx_mul(a00, sl, 16);
      s = clip48(fx_mul(ps, sl, 16) + longint'(volt_noise));
      if (s <= Q_ONE / 1000000000) return 1;
      k0 = apply_sign(fx_div(magnitude(ps), s, 32), ps < 0);
      ps = fx_mul(a10, sl, 16);
      k1 = apply_sign(fx_div(magnitude(ps), s, 32), ps < 0);
      charge = charge + fx_mul(k0, y, 32);
      charge = charge < 0 ? 0 : (charge > Q_ONE ? Q_ONE : charge);
      bias = clip48(bias + fx_mul(k1, y, 32));
      ks0 = fx_mul(k0, sl, 16);
      ks1 = fx_mul(k1, sl, 16);
      p00 = clip48(a00 - fx_mul(ks0, a00, 32));
      p01 = clip48(a01 - fx_mul(ks0, a01, 32));
      p10 = clip48(a10 - fx_mul(ks1, a00, 32));
      p11 = clip48(a11 - fx_mul(ks1, a01, 32));
      return 0;
    endfunction

    function void note(sample_t it);
      estimate_t e;
      longint v;
      logic [63:0] bm;
      e.status = 1;
      case (it.mode)
        bsoc_pkg::MODE_PREDICT:
          e.status = predict(longint'($signed(it.current)), {32'd0, it.time_step});
        bsoc_pkg::MODE_UPDATE:
          e.status = correct(longint'($signed(it.terminal_voltage)),
                             longint'($signed(it.ocv_at_soc)));
        bsoc_pkg::MODE_RESET: begin
          v = longint'($signed(it.initial_soc));
          v = v < 0 ? 0 : (v > 65536 ? 65536 : v);
          charge = v * 65536;
          bias = 0;
          load_cov();
          e.status = 0;
        end
        default: ;
      endcase
      bm = magnitude(bias) >> 16;
      if (bm > 64'h8000_0000) bm = 64'h8000_0000;
      if (bias < 0) e.bias = 32'(-longint'(bm));
      else e.bias = bm > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : bm[31:0];
      e.soc = charge[32:16];
      pending.push_back(e);
    endfunction

    function string check(estimate_t got);
      estimate_t w;
      if (pending.size() == 0) return "result beat with nothing expected";
      w = pending.pop_front();
      if (got.soc !== w.soc || got.bias !== w.bias || got.status !== w.status)
        return $sformatf("soc %h/%h bias %h/%h status %b/%b (got/expected)",
                         got.soc, w.soc, got.bias, w.bias, got.status, w.status);
      return "";
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [5:0] paddr;
  logic [63:0] pwdata, prdata;
  bsoc_sample_if smp();
  bsoc_result_if res();

  battery_soc_kalman_estimator_core uut (
    .clk(clk), .rst(rst), .sample(smp), .result(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  soc_scoreboard sb = new();
  int errors = 0;
  int send_idle = 0, recv_idle = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report(string msg);
    errors++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    estimate_t got;
    string msg;
    if (!rst && smp.valid && smp.ready) begin
      sb.note('{smp.mode, smp.current, smp.time_step, smp.terminal_voltage,
                smp.ocv_at_soc, smp.initial_soc});
    end
    if (!rst && res.valid && res.ready) begin
      got.soc = res.soc_estimate;
      got.bias = res.bias_estimate;
      got.status = res.status;
      msg = sb.check(got);
      if (msg != "") report(msg);
    end
  end

  always @(negedge clk) res.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle);

  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'd0}; pwdata <= v;
    @(negedge clk) penable <= 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel <= 0; penable <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_regs(logic [63:0] cap, logic [63:0] eff, logic [63:0] cn,
                          logic [63:0] bn, logic [63:0] sl, logic [63:0] vn);
    drain();
    write_reg(bsoc_pkg::REG_CAPACITY, cap);
    write_reg(bsoc_pkg::REG_EFFICIENCY, eff);
    write_reg(bsoc_pkg::REG_CHG_NOISE, cn);
    write_reg(bsoc_pkg::REG_BIAS_NOISE, bn);
    write_reg(bsoc_pkg::REG_OCV_SLOPE, sl);
    write_reg(bsoc_pkg::REG_VOLT_NOISE, vn);
  endtask

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send(sample_t it);
    while ($urandom_range(99) < send_idle) begin
      smp.valid <= 0;
      @(negedge clk);
    end
    smp.valid <= 1;
    smp.mode <= it.mode;
    smp.current <= it.current;
    smp.time_step <= it.time_step;
    smp.terminal_voltage <= it.terminal_voltage;
    smp.ocv_at_soc <= it.ocv_at_soc;
    smp.initial_soc <= it.initial_soc;
    do @(posedge clk); while (!smp.ready);
    @(negedge clk);
  endtask

  function automatic sample_t make(logic [1:0] m, logic [31:0] cur, logic [31:0] dt,
                                   logic [31:0] vt, logic [31:0] ocv, logic [31:0] soc);
    sample_t it;
    it.mode = m; it.current = cur; it.time_step = dt;
    it.terminal_voltage = vt; it.ocv_at_soc = ocv; it.initial_soc = soc;
    return it;
  endfunction

  function automatic sample_t random_sample();
    int r;
    sample_t it;
    r = $urandom_range(99);
    it = make(r < 45 ? bsoc_pkg::MODE_PREDICT : r < 82 ? bsoc_pkg::MODE_UPDATE :
              r < 95 ? bsoc_pkg::MODE_RESET : bsoc_pkg::MODE_UNUSED,
              $urandom, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(9) < 8) begin
      it.current = $urandom_range(40 * 65536) - 20 * 65536;
      it.time_step = $urandom_range(120 * 65536);
      it.ocv_at_soc = $urandom_range(3 * 65536, 4 * 65536 + 20000);
      it.terminal_voltage = it.ocv_at_soc + $urandom_range(26000) - 13000;
      it.initial_soc = $urandom_range(65536);
    end
    return it;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        smp.valid <= 0;
        drain();
      end
      send(random_sample());
    end
    smp.valid <= 0;
  endtask

  initial begin
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    smp.valid = 0; smp.mode = 0; smp.current = 0; smp.time_step = 0;
    smp.terminal_voltage = 0; smp.ocv_at_soc = 0; smp.initial_soc = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst = 0;

    send(make(bsoc_pkg::MODE_UPDATE, 0, 0, 32'h0003_C000, 32'h0003_8000, 0));
    send(make(bsoc_pkg::MODE_RESET, 0, 0, 0, 0, 32'h8000_0000));
    send(make(bsoc_pkg::MODE_RESET, 0, 0, 0, 0, 32'h0001_0001));
    send(make(bsoc_pkg::MODE_RESET, 0, 0, 0, 0, 32'h7FFF_FFFF));
    send(make(bsoc_pkg::MODE_PREDICT, 32'h0002_0000, 32'h003C_0000, 0, 0, 0));
    send(make(bsoc_pkg::MODE_PREDICT, 32'h0005_0000, 0, 0, 0, 0));
    send(make(bsoc_pkg::MODE_PREDICT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0));
    send(make(bsoc_pkg::MODE_PREDICT, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0));
    send(make(bsoc_pkg::MODE_RESET, 0, 0, 0, 0, 32'h0000_8000));
    send(make(bsoc_pkg::MODE_UPDATE, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    send(make(bsoc_pkg::MODE_UPDATE, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    send(make(bsoc_pkg::MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(make(bsoc_pkg::MODE_RESET, 0, 0, 0, 0, 0));
    smp.valid <= 0;
    // zero capacity, slope of one lsb and no voltage noise: skips
    set_regs(0, 1073741824, 109951, 1099512, 1, 0);
    @(negedge clk);
    send(make(bsoc_pkg::MODE_PREDICT, 32'h0001_0000, 32'h0001_0000, 0, 0, 0));
    send(make(bsoc_pkg::MODE_UPDATE, 0, 0, 32'h0004_0000, 32'h0003_0000, 0));
    smp.valid <= 0;
    // negative slope falls back to one half
    set_regs(131072, 1073741824, 109951, 1099512, 64'hFFFF_FFFF_8000_0000, 4294967);
    @(negedge clk);
    send(make(bsoc_pkg::MODE_RESET, 0, 0, 0, 0, 32'h0000_C000));
    send(make(bsoc_pkg::MODE_UPDATE, 0, 0, 32'h0003_4000, 32'h0003_8000, 0));
    send(make(bsoc_pkg::MODE_PREDICT, 32'hFFFE_0000, 32'h0100_0000, 0, 0, 0));
    smp.valid <= 0;

    send_idle = 24; recv_idle = 53;
    set_regs(131072, 1073741824, 109951, 1099512, 32768, 4294967);
    @(negedge clk) run_random(150);
    set_regs(4096, 64'h7FFF_FFFF, 64'hFF_FFFF_FFFF, 64'hFF_FFFF_FFFF, 32'h7FFF_FFFF,
             64'hFF_FFFF_FFFF);
    @(negedge clk) run_random(150);
    send_idle = 53; recv_idle = 24;
    set_regs(32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    @(negedge clk) run_random(150);
    set_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    @(negedge clk) run_random(150);
    send_idle = 0; recv_idle = 0;
    set_regs($urandom_range(1 << 20, 1 << 16), $urandom_range(1 << 30, 1 << 29),
             $urandom_range(1 << 22), $urandom_range(1 << 24),
             $urandom_range(1 << 17, 1 << 12), $urandom_range(1 << 26));
    @(negedge clk) run_random(150);
    set_regs(131072, 1073741824, 109951, 1099512, 32768, 4294967);
    @(negedge clk) run_random(150);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/bsoc_pkg.sv
hw/rtl/bsoc_if.sv
hw/rtl/bsoc_mul.sv
hw/rtl/bsoc_div.sv
hw/rtl/battery_soc_kalman_estimator_core.sv
hw/rtl/bsoc_checker.sv
dv/battery_soc_kalman_estimator_core_test.sv
